// File: hw/rtl/vpid_pkg.sv
// Shared types, register map, reset values and helpers for the velocity PID controller.
`default_nettype none

package vpid_pkg;

  // Build-time defaults
  localparam int DEF_CONTROL_FORM = 0;
  localparam int DEF_SIGNAL_WIDTH = 32;

  // Control forms
  localparam int FORM_PID  = 0;
  localparam int FORM_PI_D = 1;
  localparam int FORM_I_PD = 2;

  // Config port geometry
  localparam int CFG_AW = 5;
  localparam int CFG_DW = 32;

  typedef enum logic [2:0] {
    REG_P_GAIN    = 3'd0,
    REG_I_COEFF   = 3'd1,
    REG_D_COEFF   = 3'd2,
    REG_D_POLE    = 3'd3,
    REG_OUT_MAX   = 3'd4,
    REG_OUT_MIN   = 3'd5,
    REG_RATE_UP   = 3'd6,
    REG_RATE_DOWN = 3'd7
  } cfg_reg_t;

  typedef struct packed {
    logic signed [31:0] p_gain;
    logic        [30:0] i_coeff;
    logic        [30:0] d_coeff;
    logic        [15:0] d_pole;
    logic signed [31:0] out_max;
    logic signed [31:0] out_min;
    logic signed [31:0] rate_up;
    logic signed [31:0] rate_down;
  } pid_cfg_t;

  localparam pid_cfg_t CFG_RESET = '{
    p_gain:    32'sd65536,
    i_coeff:   31'd655360,
    d_coeff:   31'd6489,
    d_pole:    16'd649,
    out_max:   32'sd6553600,
    out_min:   -32'sd6553600,
    rate_up:   32'sd65536,
    rate_down: -32'sd65536
  };

  // Channel payloads
  typedef struct packed {
    logic signed [31:0] setpoint;
    logic signed [31:0] feedback;
  } pid_in_t;

  typedef struct packed {
    logic signed [31:0] drive;
    logic               limiting;
  } pid_out_t;

  // Controller states
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DIFF,
    ST_WAIT_I,
    ST_WAIT_D,
    ST_WAIT_F,
    ST_SUM,
    ST_MUL_P,
    ST_WAIT_P,
    ST_CLAMP,
    ST_RATE,
    ST_OUT
  } ctrl_state_t;

  // Products formed on the shared multiplier
  typedef enum logic [1:0] {
    MUL_I,   // i_coeff * error
    MUL_D,   // d_coeff * second difference
    MUL_F,   // d_pole * filtered derivative
    MUL_P    // p_gain * summed velocity
  } mul_op_t;

  typedef struct packed {
    logic    load;
    logic    diff;
    logic    mul_start;
    mul_op_t mul_op;
    logic    mul_cap;
    mul_op_t cap_op;
    logic    sum;
    logic    clamp;
    logic    rate;
    logic    out_load;
  } ctrl_cmd_t;

  typedef struct packed {
    logic mul_done;
  } dp_status_t;

  // Internal signal width, held to the supported range
  function automatic int sig_w(input int w);
    int r;
    r = w;
    if (w < 16) r = 16;
    if (w > 48) r = 48;
    return r;
  endfunction

endpackage

`default_nettype wire

// File: hw/rtl/vpid_mul.sv
// Shared sequential multiplier: signed product, Q16 rounding, saturation.
`default_nettype none

module vpid_mul #(
  parameter int SIGNAL_WIDTH = vpid_pkg::DEF_SIGNAL_WIDTH
) (
  input  wire logic                                          clk,
  input  wire logic                                          rst_n,
  input  wire logic                                          start,
  input  wire logic signed [32:0]                            a,
  input  wire logic signed [vpid_pkg::sig_w(SIGNAL_WIDTH)+2:0] b,
  output logic                                               done,
  output logic signed [vpid_pkg::sig_w(SIGNAL_WIDTH)-1:0]      res
);

  localparam int SW   = vpid_pkg::sig_w(SIGNAL_WIDTH);
  localparam int BW   = SW + 3;
  localparam int NCH  = (BW + 31) / 32;
  localparam int BPW  = NCH * 32;
  localparam int PW   = BPW + 32;
  localparam int MW   = PW - 16;
  localparam int CNTW = $clog2(NCH + 1);

  localparam logic [PW-1:0] RND   = PW'(32768);
  localparam logic [MW-1:0] LIM_P = {{(MW-SW+1){1'b0}}, {(SW-1){1'b1}}};
  localparam logic [MW-1:0] LIM_N = {{(MW-SW){1'b0}}, 1'b1, {(SW-1){1'b0}}};

  logic            neg_r;
  logic [31:0]     amag_r;
  logic [BPW-1:0]  bsh_r;
  logic [CNTW-1:0] cnt_r;
  logic [63:0]     pp_r;
  logic            pp_v_r;
  logic            pp_last_r;
  logic [PW-1:0]   acc_r;
  logic            acc_done_r;
  logic            done_r;
  logic [SW-1:0]   res_r;

  logic [32:0]     a_abs;
  logic [BW-1:0]   b_abs;
  logic [31:0]     chunk;
  logic [63:0]     pp_nxt;
  logic [PW-1:0]   acc_nxt;
  logic [MW-1:0]   mag;
  logic [MW-1:0]   lim;
  logic [MW-1:0]   mag_c;
  logic [SW-1:0]   mag_lo;
  logic [SW-1:0]   res_nxt;

  // Operand magnitudes
  always_comb begin
    a_abs = a[32] ? 33'(-a) : 33'(a);
    b_abs = b[BW-1] ? BW'(-b) : BW'(b);
  end

  // One 32x32 slice per cycle, most significant slice first
  assign chunk  = bsh_r[BPW-1 -: 32];
  assign pp_nxt = amag_r * chunk;

  // Accumulate slices, rounding constant added with the last one
  assign acc_nxt = (acc_r << 32) + PW'(pp_r) + (pp_last_r ? RND : '0);

  // Round-off shift, saturate magnitude, restore sign
  always_comb begin
    mag     = acc_r[PW-1:16];
    lim     = neg_r ? LIM_N : LIM_P;
    mag_c   = (mag > lim) ? lim : mag;
    mag_lo  = mag_c[SW-1:0];
    res_nxt = neg_r ? (~mag_lo + 1'b1) : mag_lo;
  end

  // Control flops
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r      <= '0;
      pp_v_r     <= 1'b0;
      pp_last_r  <= 1'b0;
      acc_done_r <= 1'b0;
      done_r     <= 1'b0;
    end else begin
      if (start) begin
        cnt_r <= CNTW'(NCH);
      end else if (cnt_r != '0) begin
        cnt_r <= cnt_r - 1'b1;
      end
      pp_v_r     <= (cnt_r != '0) && !start;
      pp_last_r  <= (cnt_r == CNTW'(1)) && !start;
      acc_done_r <= pp_v_r && pp_last_r;
      done_r     <= acc_done_r;
    end
  end

  // Datapath flops
  always_ff @(posedge clk) begin
    if (start) begin
      neg_r  <= a[32] ^ b[BW-1];
      amag_r <= a_abs[31:0];
      bsh_r  <= BPW'(b_abs);
      acc_r  <= '0;
    end else begin
      if (cnt_r != '0) begin
        pp_r  <= pp_nxt;
        bsh_r <= bsh_r << 32;
      end
      if (pp_v_r) begin
        acc_r <= acc_nxt;
      end
    end
    if (acc_done_r) begin
      res_r <= res_nxt;
    end
  end

  assign done = done_r;
  assign res  = res_r;

endmodule

`default_nettype wire

// File: hw/rtl/vpid_dp.sv
// Datapath: error history, velocity terms, integrator, clamp and rate limit.
`default_nettype none

module vpid_dp #(
  parameter int CONTROL_FORM = vpid_pkg::DEF_CONTROL_FORM,
  parameter int SIGNAL_WIDTH = vpid_pkg::DEF_SIGNAL_WIDTH
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire vpid_pkg::pid_cfg_t   cfg,
  input  wire vpid_pkg::pid_in_t    in_data,
  input  wire vpid_pkg::ctrl_cmd_t  cmd,
  output vpid_pkg::dp_status_t      status,
  output vpid_pkg::pid_out_t        out_data
);

  localparam int SW = vpid_pkg::sig_w(SIGNAL_WIDTH);
  localparam int BW = SW + 3;
  localparam int LW = (SW > 32) ? SW : 32;
  localparam int EW = LW + 4;

  localparam logic signed [EW-1:0] SMAX  = {{(EW-SW+1){1'b0}}, {(SW-1){1'b1}}};
  localparam logic signed [EW-1:0] SMIN  = {{(EW-SW+1){1'b1}}, {(SW-1){1'b0}}};
  localparam logic signed [EW-1:0] DMAX  = {{(EW-31){1'b0}}, {31{1'b1}}};
  localparam logic signed [EW-1:0] DMIN  = {{(EW-31){1'b1}}, {31{1'b0}}};
  localparam logic signed [EW-1:0] ZERO  = '0;

  function automatic logic signed [SW-1:0] sat_w(input logic signed [EW-1:0] x);
    logic signed [EW-1:0] y;
    y = (x > SMAX) ? SMAX : ((x < SMIN) ? SMIN : x);
    return y[SW-1:0];
  endfunction

  function automatic logic signed [31:0] sat_32(input logic signed [EW-1:0] x);
    logic signed [EW-1:0] y;
    y = (x > DMAX) ? DMAX : ((x < DMIN) ? DMIN : x);
    return y[31:0];
  endfunction

  // Loop state (reset to zero)
  logic signed [SW-1:0] last_err_r;
  logic signed [SW-1:0] older_err_r;
  logic signed [SW-1:0] last_fb_r;
  logic signed [SW-1:0] older_fb_r;
  logic signed [SW-1:0] fd_r;
  logic signed [SW-1:0] integ_r;
  logic signed [31:0]   prev_drive_r;
  logic signed [SW-1:0] os_r;

  // Per-sample working registers
  logic signed [SW-1:0] fb_r;
  logic signed [SW-1:0] err_r;
  logic signed [SW:0]   vp_r;
  logic signed [BW-1:0] dd_r;
  logic signed [SW-1:0] vi_r;
  logic signed [SW-1:0] t1_r;
  logic signed [SW-1:0] sum_r;
  logic signed [LW-1:0] lim_r;
  vpid_pkg::pid_out_t   out_r;

  logic signed [SW-1:0] fb_nxt;
  logic signed [SW-1:0] err_nxt;
  logic signed [SW:0]   vp_nxt;
  logic signed [BW-1:0] dd_nxt;
  logic signed [SW-1:0] sum_nxt;
  logic signed [LW-1:0] lim_nxt;
  logic signed [31:0]   drive_nxt;
  logic signed [SW-1:0] os_nxt;
  logic                 limiting_nxt;
  logic signed [SW-1:0] fd_nxt;
  logic signed [SW-1:0] integ_nxt;

  logic signed [EW-1:0] fb_e, sp_e, e_e, le_e, oe_e, f_e, lf_e, of_e;
  logic signed [EW-1:0] vp_e, dd_e, vi_e, sum_e, ig_e, lim_e;
  logic signed [EW-1:0] pd_e, diff_e, up_e, dn_e, sel_e;
  logic                 vi_pos, vi_neg, os_pos, os_neg, allow_i;

  logic signed [32:0]   mul_a;
  logic signed [BW-1:0] mul_b;
  logic                 mul_done;
  logic signed [SW-1:0] mul_res;

  // Error of the new sample
  always_comb begin
    fb_e    = EW'(in_data.feedback);
    fb_nxt  = sat_w(fb_e);
    sp_e    = EW'(in_data.setpoint);
    err_nxt = sat_w(sp_e - EW'(fb_nxt));
  end

  // Proportional delta and second difference for the chosen form
  always_comb begin
    e_e  = EW'(err_r);
    le_e = EW'(last_err_r);
    oe_e = EW'(older_err_r);
    f_e  = EW'(fb_r);
    lf_e = EW'(last_fb_r);
    of_e = EW'(older_fb_r);
    if (CONTROL_FORM == vpid_pkg::FORM_I_PD) begin
      vp_e = lf_e - f_e;
      dd_e = (lf_e <<< 1) - f_e - of_e;
    end else if (CONTROL_FORM == vpid_pkg::FORM_PI_D) begin
      vp_e = e_e - le_e;
      dd_e = (lf_e <<< 1) - f_e - of_e;
    end else begin
      vp_e = e_e - le_e;
      dd_e = e_e - (le_e <<< 1) + oe_e;
    end
    vp_nxt = vp_e[SW:0];
    dd_nxt = dd_e[BW-1:0];
  end

  // Multiplier operand select
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (cmd.mul_op)
      vpid_pkg::MUL_I: begin
        mul_a = {2'b00, cfg.i_coeff};
        mul_b = BW'(err_r);
      end
      vpid_pkg::MUL_D: begin
        mul_a = {2'b00, cfg.d_coeff};
        mul_b = dd_r;
      end
      vpid_pkg::MUL_F: begin
        mul_a = {17'b0, cfg.d_pole};
        mul_b = BW'(fd_r);
      end
      vpid_pkg::MUL_P: begin
        mul_a = {cfg.p_gain[31], cfg.p_gain};
        mul_b = BW'(sum_r);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  vpid_mul #(
    .SIGNAL_WIDTH(SIGNAL_WIDTH)
  ) u_mul (
    .clk  (clk),
    .rst_n(rst_n),
    .start(cmd.mul_start),
    .a    (mul_a),
    .b    (mul_b),
    .done (mul_done),
    .res  (mul_res)
  );

  // Filter and integrator updates from a finished product
  assign fd_nxt    = sat_w(EW'(t1_r) + EW'(mul_res));
  assign integ_nxt = sat_w(EW'(integ_r) + EW'(mul_res));

  // Velocity sum; integral term held off while it would grow the overshoot
  always_comb begin
    vi_pos  = !vi_r[SW-1] && (vi_r != '0);
    vi_neg  = vi_r[SW-1];
    os_pos  = !os_r[SW-1] && (os_r != '0);
    os_neg  = os_r[SW-1];
    allow_i = !((vi_pos && os_pos) || (vi_neg && os_neg));
    vi_e    = allow_i ? EW'(vi_r) : ZERO;
    sum_e   = EW'(vp_r) + EW'(fd_r) + vi_e;
    sum_nxt = sat_w(sum_e);
  end

  // Output clamp (upper bound tested first)
  always_comb begin
    ig_e = EW'(integ_r);
    if (ig_e > EW'(cfg.out_max)) begin
      lim_e = EW'(cfg.out_max);
    end else if (ig_e < EW'(cfg.out_min)) begin
      lim_e = EW'(cfg.out_min);
    end else begin
      lim_e = ig_e;
    end
    lim_nxt = lim_e[LW-1:0];
  end

  // Rate limit against the previous drive (rise test first)
  always_comb begin
    pd_e   = EW'(prev_drive_r);
    diff_e = EW'(lim_r) - pd_e;
    up_e   = pd_e + EW'(cfg.rate_up);
    dn_e   = pd_e + EW'(cfg.rate_down);
    if (diff_e > EW'(cfg.rate_up)) begin
      sel_e = up_e;
    end else if (diff_e < EW'(cfg.rate_down)) begin
      sel_e = dn_e;
    end else begin
      sel_e = EW'(lim_r);
    end
    drive_nxt = sat_32(sel_e);
  end

  // Overshoot and limiting flag from the final drive
  always_comb begin
    os_nxt       = sat_w(EW'(integ_r) - EW'(prev_drive_r));
    limiting_nxt = (EW'(integ_r) != EW'(prev_drive_r));
  end

  // Loop state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_err_r   <= '0;
      older_err_r  <= '0;
      last_fb_r    <= '0;
      older_fb_r   <= '0;
      fd_r         <= '0;
      integ_r      <= '0;
      prev_drive_r <= '0;
      os_r         <= '0;
    end else begin
      if (cmd.diff) begin
        older_err_r <= last_err_r;
        last_err_r  <= err_r;
        older_fb_r  <= last_fb_r;
        last_fb_r   <= fb_r;
      end
      if (cmd.mul_cap && (cmd.cap_op == vpid_pkg::MUL_F)) begin
        fd_r <= fd_nxt;
      end
      if (cmd.mul_cap && (cmd.cap_op == vpid_pkg::MUL_P)) begin
        integ_r <= integ_nxt;
      end
      if (cmd.rate) begin
        prev_drive_r <= drive_nxt;
      end
      if (cmd.out_load) begin
        os_r <= os_nxt;
      end
    end
  end

  // Working registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      fb_r  <= fb_nxt;
      err_r <= err_nxt;
    end
    if (cmd.diff) begin
      vp_r <= vp_nxt;
      dd_r <= dd_nxt;
    end
    if (cmd.mul_cap && (cmd.cap_op == vpid_pkg::MUL_I)) begin
      vi_r <= mul_res;
    end
    if (cmd.mul_cap && (cmd.cap_op == vpid_pkg::MUL_D)) begin
      t1_r <= mul_res;
    end
    if (cmd.sum) begin
      sum_r <= sum_nxt;
    end
    if (cmd.clamp) begin
      lim_r <= lim_nxt;
    end
    if (cmd.out_load) begin
      out_r.drive    <= prev_drive_r;
      out_r.limiting <= limiting_nxt;
    end
  end

  assign status.mul_done = mul_done;
  assign out_data        = out_r;

endmodule

`default_nettype wire

// File: hw/rtl/vpid_ctrl.sv
// Controller: sequences one sample through the datapath and owns the handshakes.
`default_nettype none

module vpid_ctrl (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_valid,
  output logic                      in_stall,
  output logic                      out_valid,
  input  wire logic                 out_stall,
  input  wire vpid_pkg::dp_status_t status,
  output vpid_pkg::ctrl_cmd_t       cmd
);

  vpid_pkg::ctrl_state_t state_r;
  vpid_pkg::ctrl_state_t state_nxt;
  logic                  out_valid_r;
  logic                  out_valid_nxt;
  logic                  out_free;

  // Output register can take a new result
  assign out_free = !out_valid_r || !out_stall;

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      vpid_pkg::ST_IDLE:   if (in_valid) state_nxt = vpid_pkg::ST_DIFF;
      vpid_pkg::ST_DIFF:   state_nxt = vpid_pkg::ST_WAIT_I;
      vpid_pkg::ST_WAIT_I: if (status.mul_done) state_nxt = vpid_pkg::ST_WAIT_D;
      vpid_pkg::ST_WAIT_D: if (status.mul_done) state_nxt = vpid_pkg::ST_WAIT_F;
      vpid_pkg::ST_WAIT_F: if (status.mul_done) state_nxt = vpid_pkg::ST_SUM;
      vpid_pkg::ST_SUM:    state_nxt = vpid_pkg::ST_MUL_P;
      vpid_pkg::ST_MUL_P:  state_nxt = vpid_pkg::ST_WAIT_P;
      vpid_pkg::ST_WAIT_P: if (status.mul_done) state_nxt = vpid_pkg::ST_CLAMP;
      vpid_pkg::ST_CLAMP:  state_nxt = vpid_pkg::ST_RATE;
      vpid_pkg::ST_RATE:   state_nxt = vpid_pkg::ST_OUT;
      vpid_pkg::ST_OUT:    if (out_free) state_nxt = vpid_pkg::ST_IDLE;
      default:             state_nxt = vpid_pkg::ST_IDLE;
    endcase
  end

  // Datapath commands
  always_comb begin
    cmd        = '0;
    cmd.mul_op = vpid_pkg::MUL_I;
    cmd.cap_op = vpid_pkg::MUL_I;
    unique case (state_r)
      vpid_pkg::ST_IDLE: begin
        cmd.load = in_valid;
      end
      vpid_pkg::ST_DIFF: begin
        cmd.diff      = 1'b1;
        cmd.mul_start = 1'b1;
        cmd.mul_op    = vpid_pkg::MUL_I;
      end
      vpid_pkg::ST_WAIT_I: begin
        cmd.mul_cap   = status.mul_done;
        cmd.cap_op    = vpid_pkg::MUL_I;
        cmd.mul_start = status.mul_done;
        cmd.mul_op    = vpid_pkg::MUL_D;
      end
      vpid_pkg::ST_WAIT_D: begin
        cmd.mul_cap   = status.mul_done;
        cmd.cap_op    = vpid_pkg::MUL_D;
        cmd.mul_start = status.mul_done;
        cmd.mul_op    = vpid_pkg::MUL_F;
      end
      vpid_pkg::ST_WAIT_F: begin
        cmd.mul_cap = status.mul_done;
        cmd.cap_op  = vpid_pkg::MUL_F;
      end
      vpid_pkg::ST_SUM: begin
        cmd.sum = 1'b1;
      end
      vpid_pkg::ST_MUL_P: begin
        cmd.mul_start = 1'b1;
        cmd.mul_op    = vpid_pkg::MUL_P;
      end
      vpid_pkg::ST_WAIT_P: begin
        cmd.mul_cap = status.mul_done;
        cmd.cap_op  = vpid_pkg::MUL_P;
      end
      vpid_pkg::ST_CLAMP: begin
        cmd.clamp = 1'b1;
      end
      vpid_pkg::ST_RATE: begin
        cmd.rate = 1'b1;
      end
      vpid_pkg::ST_OUT: begin
        cmd.out_load = out_free;
      end
      default: begin
        cmd.load = 1'b0;
      end
    endcase
  end

  // Result valid: set on load, cleared when the transaction completes
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= vpid_pkg::ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_stall  = (state_r != vpid_pkg::ST_IDLE);
  assign out_valid = out_valid_r;

endmodule

`default_nettype wire

// File: hw/rtl/velocity_pid_controller.sv
// Velocity PID controller: top level with the configuration registers.
// Each product takes S 32x32 slices, S = (W+34)/32 rounded down, W = SIGNAL_WIDTH
//   held to 16..48 (S=2 at 32 bits). One sample at a time: a new sample is taken
//   only once the last one is through; the four products of a sample run one after
//   another on the single shared multiplier.
// Reset (rst_n low, synchronous): loop state cleared, registers to defaults, no result pending.
`default_nettype none

module velocity_pid_controller #(
  parameter int CONTROL_FORM = vpid_pkg::DEF_CONTROL_FORM,
  parameter int SIGNAL_WIDTH = vpid_pkg::DEF_SIGNAL_WIDTH
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire vpid_pkg::pid_in_t             in_data,
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output vpid_pkg::pid_out_t                 out_data,
  input  wire logic                          cfg_psel,
  input  wire logic                          cfg_penable,
  input  wire logic                          cfg_pwrite,
  input  wire logic [vpid_pkg::CFG_AW-1:0]   cfg_paddr,
  input  wire logic [vpid_pkg::CFG_DW-1:0]   cfg_pwdata,
  output logic [vpid_pkg::CFG_DW-1:0]        cfg_prdata,
  output logic                               cfg_pready
);

  vpid_pkg::pid_cfg_t   cfg_r;
  vpid_pkg::pid_cfg_t   cfg_nxt;
  vpid_pkg::cfg_reg_t   reg_idx;
  logic                 cfg_wr;
  vpid_pkg::ctrl_cmd_t  cmd;
  vpid_pkg::dp_status_t status;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign reg_idx    = vpid_pkg::cfg_reg_t'(cfg_paddr[4:2]);

  // Register write decode
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_wr) begin
      unique case (reg_idx)
        vpid_pkg::REG_P_GAIN:    cfg_nxt.p_gain    = cfg_pwdata;
        vpid_pkg::REG_I_COEFF:   cfg_nxt.i_coeff   = cfg_pwdata[30:0];
        vpid_pkg::REG_D_COEFF:   cfg_nxt.d_coeff   = cfg_pwdata[30:0];
        vpid_pkg::REG_D_POLE:    cfg_nxt.d_pole    = cfg_pwdata[15:0];
        vpid_pkg::REG_OUT_MAX:   cfg_nxt.out_max   = cfg_pwdata;
        vpid_pkg::REG_OUT_MIN:   cfg_nxt.out_min   = cfg_pwdata;
        vpid_pkg::REG_RATE_UP:   cfg_nxt.rate_up   = cfg_pwdata;
        vpid_pkg::REG_RATE_DOWN: cfg_nxt.rate_down = cfg_pwdata;
        default:                 cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= vpid_pkg::CFG_RESET;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  // Register read mux
  always_comb begin
    unique case (reg_idx)
      vpid_pkg::REG_P_GAIN:    cfg_prdata = cfg_r.p_gain;
      vpid_pkg::REG_I_COEFF:   cfg_prdata = {1'b0, cfg_r.i_coeff};
      vpid_pkg::REG_D_COEFF:   cfg_prdata = {1'b0, cfg_r.d_coeff};
      vpid_pkg::REG_D_POLE:    cfg_prdata = {16'b0, cfg_r.d_pole};
      vpid_pkg::REG_OUT_MAX:   cfg_prdata = cfg_r.out_max;
      vpid_pkg::REG_OUT_MIN:   cfg_prdata = cfg_r.out_min;
      vpid_pkg::REG_RATE_UP:   cfg_prdata = cfg_r.rate_up;
      vpid_pkg::REG_RATE_DOWN: cfg_prdata = cfg_r.rate_down;
      default:                 cfg_prdata = '0;
    endcase
  end

  vpid_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .status   (status),
    .cmd      (cmd)
  );

  vpid_dp #(
    .CONTROL_FORM(CONTROL_FORM),
    .SIGNAL_WIDTH(SIGNAL_WIDTH)
  ) u_dp (
    .clk     (clk),
    .rst_n   (rst_n),
    .cfg     (cfg_r),
    .in_data (in_data),
    .cmd     (cmd),
    .status  (status),
    .out_data(out_data)
  );

endmodule

`default_nettype wire

// File: hw/rtl/vpid_checker.sv
// Port-level checks for the velocity PID controller, bound to the top level.
`default_nettype none

module vpid_checker (
  input wire logic                        clk,
  input wire logic                        rst_n,
  input wire logic                        in_valid,
  input wire logic                        in_stall,
  input wire logic                        out_valid,
  input wire logic                        out_stall,
  input wire vpid_pkg::pid_out_t          out_data
);

  // A stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("result changed or dropped while stalled");

  // One sample at a time: busy right after a transaction is taken
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("input taken again before the sample finished");

  // A result only appears from a sample in flight
  a_result_from_work: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_stall))
    else $error("result raised with no sample in flight");

  // Input side is open again in the cycle a new result is raised
  a_idle_after_result: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> !in_stall)
    else $error("controller did not return to idle after the result");

endmodule

bind velocity_pid_controller vpid_checker u_vpid_checker (.*);

`default_nettype wire
